>>> design/bsd_pkg.sv
// bsd_pkg: shared widths and controller/datapath handshake structs
// for the short division block. No dependencies.
`timescale 1ns / 1ps

package bsd_pkg;

	localparam int LIMB_W  = 17;
	localparam int DIV_W   = 14;
	localparam int TDATA_W = 24;

	typedef struct packed {
		logic load;
		logic mul;
		logic step;
		logic finish;
	} bsd_cmd_t;

	typedef struct packed {
		logic out_busy;
	} bsd_sts_t;

endpackage

>>> design/bignum_short_division_by_word.sv
// Each input word is loaded, multiplied into the remainder, divided in radix-4 steps at
// LIMB_BASE = 100000 and finished into the output word register once that register is free;
// a new input word is taken only after the previous one is finished. The radix-4 restoring
// divider (two quotient bits a cycle) works over the 31-bit remainder*LIMB_BASE+limb.
// Reset (arst_n low): divisor 1, remainder and nonzero flag cleared, no word pending.
`timescale 1ns / 1ps

module bignum_short_division_by_word
	import bsd_pkg::*;
#(
	parameter int LIMB_BASE = 100000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [DIV_W-1:0]   cfg_wdata,     // divisor
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // [16:0] limb, rest zero
	input  logic               s_axis_tlast,  // last_limb
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // [16:0] quotient_limb, rest zero
	output logic               m_axis_tuser,  // [0] any_nonzero
	output logic               m_axis_tlast   // last_out
);

	localparam int M_MAX = (2**DIV_W - 1) * LIMB_BASE + 2**LIMB_W;
	localparam int M_W   = $clog2(M_MAX);
	localparam int ITER  = (M_W + 1) / 2;

	bsd_cmd_t          cmd;
	bsd_sts_t          sts;
	logic [LIMB_W-1:0] quot;

	bsd_ctrl #(
		.ITER(ITER)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsd_datapath #(
		.LIMB_BASE (LIMB_BASE),
		.ITER      (ITER)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_limb         (s_axis_tdata[LIMB_W-1:0]),
		.in_last         (s_axis_tlast),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_quotient    (quot),
		.out_any_nonzero (m_axis_tuser),
		.out_last        (m_axis_tlast)
	);

	assign m_axis_tdata = TDATA_W'(quot);

endmodule

>>> design/bsd_ctrl.sv
// bsd_ctrl: sequencer for the short division block.
// Steps load, multiply, radix-4 divide and finish. Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_ctrl
	import bsd_pkg::*;
#(
	parameter int ITER = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  bsd_sts_t sts,
	output bsd_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam int CNT_W = $clog2(ITER);

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == CNT_W'(ITER - 1))
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.mul)
				cnt_q <= '0;
			else if (cmd.step)
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

endmodule

>>> design/bsd_datapath.sv
// bsd_datapath: divisor register, running remainder, limb multiply,
// two-bit-per-cycle restoring divider and output word register. Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_datapath
	import bsd_pkg::*;
#(
	parameter int LIMB_BASE = 100000,
	parameter int ITER      = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [DIV_W-1:0]  cfg_wdata,
	input  logic [LIMB_W-1:0] in_limb,
	input  logic              in_last,
	input  bsd_cmd_t          cmd,
	output bsd_sts_t          sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [LIMB_W-1:0] out_quotient,
	output logic              out_any_nonzero,
	output logic              out_last
);

	localparam int DW = 2 * ITER;

	logic [DIV_W-1:0]  divisor_q;
	logic [DIV_W-1:0]  d_q;
	logic [DIV_W-1:0]  rem_q;
	logic              nz_q;
	logic [LIMB_W-1:0] limb_q;
	logic              last_q;
	logic [DW-1:0]     num_q;
	logic [DW-1:0]     quo_q;
	logic [DIV_W-1:0]  part_q;
	logic              out_valid_q;
	logic [LIMB_W-1:0] out_quot_q;
	logic              out_nz_q;
	logic              out_last_q;

	logic [DW-1:0]     m_next;
	logic [DIV_W:0]    r_a;
	logic [DIV_W:0]    r_b;
	logic [DIV_W-1:0]  r_a2;
	logic [DIV_W-1:0]  r_b2;
	logic              ge_a;
	logic              ge_b;
	logic              q_nz;
	logic [LIMB_W-1:0] q_sat;

	assign m_next = DW'(rem_q) * DW'(LIMB_BASE) + DW'(limb_q);

	always_comb begin
		r_a  = {part_q, num_q[DW-1]};
		ge_a = (r_a >= {1'b0, d_q});
		r_a2 = ge_a ? DIV_W'(r_a - {1'b0, d_q}) : r_a[DIV_W-1:0];
		r_b  = {r_a2, num_q[DW-2]};
		ge_b = (r_b >= {1'b0, d_q});
		r_b2 = ge_b ? DIV_W'(r_b - {1'b0, d_q}) : r_b[DIV_W-1:0];
	end

	assign q_nz  = (quo_q != '0);
	assign q_sat = (quo_q > DW'(LIMB_BASE - 1)) ? LIMB_W'(LIMB_BASE - 1)
		: quo_q[LIMB_W-1:0];

	assign sts.out_busy = out_valid_q & ~out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q   <= DIV_W'(1);
			rem_q       <= '0;
			nz_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				divisor_q <= cfg_wdata;
			if (cmd.finish) begin
				rem_q       <= last_q ? '0 : part_q;
				nz_q        <= last_q ? 1'b0 : (nz_q | q_nz);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			limb_q <= in_limb;
			last_q <= in_last;
		end
		if (cmd.mul) begin
			num_q  <= m_next;
			part_q <= '0;
			quo_q  <= '0;
			d_q    <= (divisor_q == '0) ? DIV_W'(1) : divisor_q;
		end else if (cmd.step) begin
			num_q  <= {num_q[DW-3:0], 2'b00};
			part_q <= r_b2;
			quo_q  <= {quo_q[DW-3:0], ge_a, ge_b};
		end
		if (cmd.finish) begin
			out_quot_q <= q_sat;
			out_nz_q   <= nz_q | q_nz;
			out_last_q <= last_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_quotient    = out_quot_q;
	assign out_any_nonzero = out_nz_q;
	assign out_last        = out_last_q;

endmodule

>>> design/bsd_checker.sv
// bsd_checker: port-level assertions for bignum_short_division_by_word,
// attached by bind. Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_checker
	import bsd_pkg::*;
#(
	parameter int LIMB_BASE = 100000
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic               m_axis_tuser,
	input logic               m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a division is in progress");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[LIMB_W-1:0] <= LIMB_W'(LIMB_BASE - 1)
		&& m_axis_tdata[TDATA_W-1:LIMB_W] == '0)
		else $error("quotient word out of range");

	a_nonzero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[LIMB_W-1:0] != '0 |-> m_axis_tuser)
		else $error("nonzero quotient without nonzero flag");

endmodule

bind bignum_short_division_by_word bsd_checker #(
	.LIMB_BASE(LIMB_BASE)
) u_bsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

>>> sim/bignum_short_division_by_word_test.sv
// Testbench for bignum_short_division_by_word: streams base-100000 limbs under random
// handshake pressure and divisor changes and checks every quotient word against a predictor.
// Depends on bsd_pkg and the block under test.
`timescale 1ns / 1ps

module bignum_short_division_by_word_test;
	import bsd_pkg::*;

	localparam int LIMB_BASE = 100000;
	localparam int DIV_LATENCY = 18;
	localparam int MAX_LIMB = (1 << LIMB_W) - 1;
	localparam int MAX_DIV = (1 << DIV_W) - 1;

	typedef struct {
		logic [LIMB_W-1:0] limb;
		logic              last;
	} limb_word_t;

	typedef struct {
		logic [LIMB_W-1:0] quotient;
		logic              any_nonzero;
		logic              last;
	} quot_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [DIV_W-1:0]   cfg_wdata = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata = '0;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tuser;
	logic               m_axis_tlast;

	limb_word_t pending_limbs[$];
	quot_word_t quotients_due[$];
	int limbs_issued = 0;
	int limbs_accepted = 0;
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic rx_hold = 1'b0;

	logic [DIV_W-1:0] divisor_now = 1;
	logic [DIV_W-1:0] remainder_now = '0;
	logic             nonzero_now = 1'b0;

	bignum_short_division_by_word dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic void predict_quotient(input logic [LIMB_W-1:0] limb, input logic last);
		longint unsigned dvs, m, q;
		quot_word_t w;
		dvs = (divisor_now == '0) ? 1 : longint'(divisor_now);
		m = longint'(remainder_now) * LIMB_BASE + longint'(limb);
		q = m / dvs;
		remainder_now = DIV_W'(m % dvs);
		if (q > LIMB_BASE - 1)
			q = LIMB_BASE - 1;
		if (q != 0)
			nonzero_now = 1'b1;
		w.quotient = LIMB_W'(q);
		w.any_nonzero = nonzero_now;
		w.last = last;
		quotients_due.push_back(w);
		if (last) begin
			remainder_now = '0;
			nonzero_now = 1'b0;
		end
	endfunction

	// sender
	always @(posedge clk) begin
		limb_word_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_quotient(s_axis_tdata[LIMB_W-1:0], s_axis_tlast);
				limbs_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_limbs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_limbs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {{(TDATA_W-LIMB_W){1'b0}}, nxt.limb};
					s_axis_tlast <= nxt.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		quot_word_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (quotients_due.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected word, expected none, actual q=%0d nz=%0b last=%0b",
						$time, m_axis_tdata[LIMB_W-1:0], m_axis_tuser, m_axis_tlast);
				end else begin
					want = quotients_due.pop_front();
					if (m_axis_tdata[LIMB_W-1:0] !== want.quotient ||
							m_axis_tuser !== want.any_nonzero || m_axis_tlast !== want.last) begin
						mismatch_count++;
						$display("%0t: expected q=%0d nz=%0b last=%0b, actual q=%0d nz=%0b last=%0b",
							$time, want.quotient, want.any_nonzero, want.last,
							m_axis_tdata[LIMB_W-1:0], m_axis_tuser, m_axis_tlast);
					end
				end
			end
			m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// long output stall so the input side backs up
	initial begin
		wait (limbs_accepted >= 1500 && pending_limbs.size() >= 40);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("bignum_short_division_by_word: mismatch");
		$finish;
	end

	task automatic queue_limb(input int limb, input bit last);
		limb_word_t w;
		w.limb = LIMB_W'(limb);
		w.last = last;
		pending_limbs.push_back(w);
		limbs_issued++;
	endtask

	function automatic int rand_limb();
		int sel;
		sel = $urandom_range(99);
		if (sel < 84)
			return $urandom_range(LIMB_BASE - 1);
		if (sel < 94)
			return $urandom_range(MAX_LIMB, LIMB_BASE);
		case ($urandom_range(2))
			0: return 0;
			1: return LIMB_BASE - 1;
			default: return MAX_LIMB;
		endcase
	endfunction

	task automatic wait_idle();
		while (limbs_accepted != limbs_issued || quotients_due.size() != 0)
			@(posedge clk);
		repeat (DIV_LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_divisor(input logic [DIV_W-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		divisor_now = d;
	endtask

	initial begin
		int phase_limbs, n;
		logic [DIV_W-1:0] d;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset divisor of one, out-of-range limbs saturate
		queue_limb(0, 0);
		queue_limb(LIMB_BASE - 1, 0);
		queue_limb(MAX_LIMB, 0);
		queue_limb(LIMB_BASE, 1);
		wait_idle();

		set_divisor(DIV_W'(MAX_DIV));
		queue_limb(LIMB_BASE - 1, 0);
		queue_limb(MAX_LIMB, 0);
		queue_limb(0, 0);
		queue_limb(65536, 1);
		wait_idle();

		// zero divisor behaves as one
		set_divisor(0);
		queue_limb(12345, 0);
		queue_limb(MAX_LIMB, 1);
		wait_idle();

		set_divisor(7);
		queue_limb(0, 0);
		queue_limb(0, 1);
		queue_limb(3, 0);
		queue_limb(MAX_LIMB, 0);
		queue_limb(0, 1);
		queue_limb(6, 0);
		wait_idle();

		// kept remainder above the new divisor
		set_divisor(2);
		queue_limb(0, 0);
		queue_limb(1, 1);
		wait_idle();

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 48 : 0;
			recv_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 36 : 0;
			for (int k = 0; k < 4; k++) begin
				case (k)
					0: d = DIV_W'($urandom_range(MAX_DIV, 1));
					1: d = DIV_W'($urandom_range(20, 1));
					2: begin
						case ($urandom_range(3))
							0: d = 0;
							1: d = 1;
							2: d = DIV_W'(MAX_DIV);
							default: d = DIV_W'(MAX_DIV - 1);
						endcase
					end
					default: d = DIV_W'($urandom_range(MAX_DIV));
				endcase
				set_divisor(d);
				phase_limbs = 0;
				while (phase_limbs < 165) begin
					n = $urandom_range(12, 1);
					for (int i = 0; i < n; i++)
						queue_limb(rand_limb(), (i == n - 1) && (phase_limbs + n < 165 ||
							$urandom_range(99) < 80));
					phase_limbs += n;
				end
				wait_idle();
			end
		end

		if (mismatch_count == 0)
			$display("bignum_short_division_by_word: match");
		else
			$display("bignum_short_division_by_word: mismatch");
		$finish;
	end

endmodule

>>> files.f
design/bsd_pkg.sv
design/bsd_ctrl.sv
design/bsd_datapath.sv
design/bignum_short_division_by_word.sv
design/bsd_checker.sv
sim/bignum_short_division_by_word_test.sv
